@@ rtl/atup_pkg.sv @@
`default_nettype none

package atup_pkg;

    localparam int unsigned INDEX_BITS = 16;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned RADIX_W    = 6;
    localparam int unsigned DIGIT_W    = 6;

    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_DEC;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    // letters map to 10..35
    localparam logic [CHAR_W-1:0] UP_BIAS  = CH_UP_A - 8'd10;
    localparam logic [CHAR_W-1:0] LO_BIAS  = CH_LO_A - 8'd10;

    typedef enum logic [4:0] {
        PH_DONE   = 5'b00001,
        PH_LEAD   = 5'b00010,
        PH_SIGNED = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } t_phase;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } t_digit;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_digit digit_value(input logic [CHAR_W-1:0] c);
        t_digit d;
        logic [CHAR_W-1:0] diff;
        d.ok  = 1'b1;
        diff  = '0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            diff = c - CH_ZERO;
        end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
            diff = c - UP_BIAS;
        end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
            diff = c - LO_BIAS;
        end else begin
            d.ok = 1'b0;
        end
        d.val = diff[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ascii_to_unsigned_parser_unit.sv @@
// result path: the terminating character's transaction loads the input register, and its
//   result is loaded into the result register when the input register's item moves on
// throughput: one character per cycle while results are not stalled; the per-character step
//   (decode, 32x6 multiply-add, overflow check) is combinational, input to result register
// reset: synchronous active-low i_rst_n empties both registers, sets radix to 10 and
//   leaves the parser waiting for a start mark
`default_nettype none

module ascii_to_unsigned_parser_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [atup_pkg::RADIX_W-1:0]         i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_first_char,
    input  wire logic [atup_pkg::CHAR_W-1:0]          i_char_code,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic      [atup_pkg::VALUE_W-1:0]         o_value,
    output logic      [atup_pkg::INDEX_BITS-1:0]      o_end_index,
    output logic                                      o_digits_seen,
    output logic                                      o_overflowed,
    output logic                                      o_minus_sign
);
    import atup_pkg::*;

    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

    logic [RADIX_W-1:0]    r_radix;
    logic                  r_in_valid, n_in_valid;
    logic                  r_in_first;
    logic [CHAR_W-1:0]     r_in_char;

    t_phase                r_phase, n_phase;
    logic [RADIX_W-1:0]    r_base, n_base;
    logic [VALUE_W-1:0]    r_acc, n_acc;
    logic                  r_seen, n_seen;
    logic                  r_over, n_over;
    logic                  r_neg, n_neg;
    logic [INDEX_BITS-1:0] r_idx, n_idx;

    logic                  r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic [INDEX_BITS-1:0] r_end_index, n_end_index;
    logic                  r_dseen, n_dseen;
    logic                  r_ovf, n_ovf;
    logic                  r_minus, n_minus;

    logic                  in_take;
    logic                  adv;
    logic                  emit;

    t_phase                eff_phase;
    logic [RADIX_W-1:0]    eff_base;
    logic [VALUE_W-1:0]    eff_acc;
    logic                  eff_seen, eff_over, eff_neg;
    logic [INDEX_BITS-1:0] eff_idx;

    logic                  cand_zero;
    logic [RADIX_W-1:0]    cand_base;
    logic [RADIX_W-1:0]    step_base;
    t_digit                dig;
    logic                  dig_ok;
    logic [VALUE_W-1:0]    mac_sum;
    logic                  mac_carry;

    // item in the input register moves on when the result register can take a result
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_take    = i_in_valid && o_in_ready;
    assign n_in_valid = in_take ? 1'b1 : (adv ? 1'b0 : r_in_valid);

    // start mark restarts the parser on this very character
    assign eff_phase = r_in_first ? PH_LEAD : r_phase;
    assign eff_base  = r_in_first ? '0 : r_base;
    assign eff_acc   = r_in_first ? '0 : r_acc;
    assign eff_seen  = r_in_first ? 1'b0 : r_seen;
    assign eff_over  = r_in_first ? 1'b0 : r_over;
    assign eff_neg   = r_in_first ? 1'b0 : r_neg;
    assign eff_idx   = r_in_first ? '0
                     : ((r_idx != IDX_MAX) ? r_idx + INDEX_BITS'(1) : r_idx);

    assign cand_zero = ((r_radix == RADIX_AUTO) || (r_radix == RADIX_HEX))
                       && (r_in_char == CH_ZERO);
    assign cand_base = (r_radix == RADIX_AUTO) ? RADIX_DEC : r_radix;
    assign step_base = ((eff_phase == PH_LEAD) || (eff_phase == PH_SIGNED))
                       ? cand_base : eff_base;

    assign dig    = digit_value(r_in_char);
    assign dig_ok = dig.ok && (dig.val < step_base);

    atup_mac u_mac (
        .i_acc   (eff_acc),
        .i_base  (step_base),
        .i_digit (dig.val),
        .o_sum   (mac_sum),
        .o_carry (mac_carry)
    );

    always_comb begin
        logic do_cand;
        logic do_digit;
        logic step_seen;
        do_cand   = 1'b0;
        do_digit  = 1'b0;
        step_seen = eff_seen;
        emit      = 1'b0;
        n_phase   = eff_phase;
        n_base    = eff_base;
        n_acc     = eff_acc;
        n_seen    = eff_seen;
        n_over    = eff_over;
        n_neg     = eff_neg;
        n_idx     = eff_idx;

        unique case (eff_phase)
            PH_LEAD: begin
                if (is_space(r_in_char)) begin
                    n_phase = PH_LEAD;
                end else if (r_in_char == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (r_in_char == CH_PLUS) begin
                    n_phase = PH_SIGNED;
                end else begin
                    do_cand = 1'b1;
                end
            end
            PH_SIGNED: begin
                do_cand = 1'b1;
            end
            PH_ZERO: begin
                if ((r_in_char == CH_LO_X) || (r_in_char == CH_UP_X)) begin
                    n_base  = RADIX_HEX;
                    n_phase = PH_DIGITS;
                end else begin
                    // the leading zero counts as a digit of value zero
                    step_seen = 1'b1;
                    n_seen    = 1'b1;
                    do_digit  = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_digit = 1'b1;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        if (do_cand) begin
            if (cand_zero) begin
                n_base  = (r_radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
                n_phase = PH_ZERO;
            end else begin
                n_base   = cand_base;
                do_digit = 1'b1;
            end
        end

        if (do_digit) begin
            n_phase = PH_DIGITS;
            if (!dig_ok) begin
                emit    = 1'b1;
                n_phase = PH_DONE;
            end else if (eff_over || mac_carry) begin
                n_over = 1'b1;
                n_seen = 1'b1;
            end else begin
                n_acc  = mac_sum;
                n_seen = 1'b1;
            end
        end

        // characters outside a string leave the state alone
        if (!r_in_first && (r_phase == PH_DONE)) begin
            emit    = 1'b0;
            n_phase = r_phase;
            n_base  = r_base;
            n_acc   = r_acc;
            n_seen  = r_seen;
            n_over  = r_over;
            n_neg   = r_neg;
            n_idx   = r_idx;
        end

        if (eff_over) begin
            n_value = '1;
        end else if (eff_neg) begin
            n_value = ~eff_acc + VALUE_W'(1);
        end else begin
            n_value = eff_acc;
        end
        n_end_index = step_seen ? eff_idx : '0;
        n_dseen     = step_seen;
        n_ovf       = eff_over;
        n_minus     = eff_neg;

        if (adv && emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_DONE;
            r_base      <= '0;
            r_acc       <= '0;
            r_seen      <= 1'b0;
            r_over      <= 1'b0;
            r_neg       <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_radix <= i_cfg_data;
            end
            if (adv) begin
                r_phase <= n_phase;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_seen  <= n_seen;
                r_over  <= n_over;
                r_neg   <= n_neg;
                r_idx   <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_first <= i_first_char;
            r_in_char  <= i_char_code;
        end
        if (adv && emit) begin
            r_value     <= n_value;
            r_end_index <= n_end_index;
            r_dseen     <= n_dseen;
            r_ovf       <= n_ovf;
            r_minus     <= n_minus;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_value;
    assign o_end_index   = r_end_index;
    assign o_digits_seen = r_dseen;
    assign o_overflowed  = r_ovf;
    assign o_minus_sign  = r_minus;

endmodule

`default_nettype wire

@@ rtl/atup_mac.sv @@
`default_nettype none

module atup_mac (
    input  wire logic [atup_pkg::VALUE_W-1:0] i_acc,
    input  wire logic [atup_pkg::RADIX_W-1:0] i_base,
    input  wire logic [atup_pkg::DIGIT_W-1:0] i_digit,
    output logic      [atup_pkg::VALUE_W-1:0] o_sum,
    output logic                              o_carry
);
    import atup_pkg::*;

    localparam int unsigned PROD_W = VALUE_W + RADIX_W;

    logic [PROD_W-1:0] prod;

    // acc * base + digit never wraps in PROD_W bits
    assign prod    = PROD_W'(i_acc) * PROD_W'(i_base) + PROD_W'(i_digit);
    assign o_sum   = prod[VALUE_W-1:0];
    assign o_carry = |prod[PROD_W-1:VALUE_W];

endmodule

`default_nettype wire

@@ rtl/atup_checker.sv @@
`default_nettype none

module atup_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 o_in_ready,
    input  wire logic                                 o_out_valid,
    input  wire logic                                 i_out_ready,
    input  wire logic [atup_pkg::VALUE_W-1:0]         o_value,
    input  wire logic [atup_pkg::INDEX_BITS-1:0]      o_end_index,
    input  wire logic                                 o_digits_seen,
    input  wire logic                                 o_overflowed,
    input  wire logic                                 o_minus_sign
);
    import atup_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value)
            && $stable(o_end_index) && $stable(o_digits_seen)
            && $stable(o_overflowed) && $stable(o_minus_sign))
        else $error("stalled result changed");

    // saturation shows all ones and always counts as digits seen
    a_ovf_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflowed |-> (o_value == '1) && o_digits_seen)
        else $error("overflow result malformed");

    // no digits means zero value and zero end index
    a_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_digits_seen |-> (o_value == '0) && (o_end_index == '0)
            && !o_overflowed)
        else $error("empty result malformed");

    // with the result register empty the input side never stalls
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind ascii_to_unsigned_parser_unit atup_checker u_atup_checker (.*);

`default_nettype wire

@@ sim/tb_ascii_to_unsigned_parser_unit.sv @@
`timescale 1ns / 1ps

module tb_ascii_to_unsigned_parser_unit;
    import atup_pkg::*;

    typedef struct packed {
        logic              first;
        logic [CHAR_W-1:0] code;
    } t_char_item;

    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [INDEX_BITS-1:0] end_index;
        logic                  digits_seen;
        logic                  overflowed;
        logic                  minus_sign;
    } t_number;

    typedef enum logic [1:0] {
        DG_NONE,
        DG_SEEN,
        DG_OVER
    } t_digit_state;

    localparam logic [6:0]        NO_DIGIT = 7'd64;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam int unsigned       HOLD_CYCLES = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [RADIX_W-1:0]    i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_first_char = 1'b0;
    logic [CHAR_W-1:0]     i_char_code = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [VALUE_W-1:0]    o_value;
    logic [INDEX_BITS-1:0] o_end_index;
    logic                  o_digits_seen;
    logic                  o_overflowed;
    logic                  o_minus_sign;

    ascii_to_unsigned_parser_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_first_char  (i_first_char),
        .i_char_code   (i_char_code),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_end_index   (o_end_index),
        .o_digits_seen (o_digits_seen),
        .o_overflowed  (o_overflowed),
        .o_minus_sign  (o_minus_sign)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // parser state as the block should hold it
    logic [RADIX_W-1:0]    cfg_radix = RADIX_RESET;
    t_phase                prs_phase = PH_DONE;
    logic [RADIX_W-1:0]    prs_base = '0;
    logic [VALUE_W-1:0]    prs_acc = '0;
    t_digit_state          prs_digits = DG_NONE;
    logic                  prs_neg = 1'b0;
    logic [INDEX_BITS-1:0] prs_idx = '0;

    t_char_item pending_chars[$];
    t_number    expected_numbers[$];

    bit         in_taken = 1'b0;
    bit         quiet = 1'b0;
    bit         pressure_arm = 1'b0;
    logic       long_hold = 1'b0;
    bit         mark_next = 1'b0;
    int         tx_idle_left = 0;
    int         rx_idle_left = 0;
    t_char_item next_item;
    bit         pred_got;
    t_number    pred_num;
    t_number    want_num;
    t_number    seen_num;
    int         chars_taken = 0;
    int         chars_queued = 0;
    int         numbers_checked = 0;
    int         mismatches = 0;
    int         strings_sent = 0;
    int         settings_used = 0;

    task automatic add_digit(input logic [6:0] d);
        logic [63:0] t;
        t = 64'(prs_acc) * 64'(prs_base) + 64'(d);
        if (prs_digits == DG_OVER || t > 64'hffff_ffff) begin
            prs_digits = DG_OVER;
        end else begin
            prs_acc = t[VALUE_W-1:0];
            prs_digits = DG_SEEN;
        end
    endtask

    task automatic digit_or_end(input logic [CHAR_W-1:0] c, output bit got,
                                output t_number num);
        logic [6:0] d;
        got = 1'b0;
        num = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 7'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = 7'(c - UP_BIAS);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = 7'(c - LO_BIAS);
        end else begin
            d = NO_DIGIT;
        end
        if (d < 7'(prs_base)) begin
            add_digit(d);
        end else begin
            got = 1'b1;
            if (prs_digits == DG_OVER) begin
                num.value = '1;
            end else if (prs_neg) begin
                num.value = 32'd0 - prs_acc;
            end else begin
                num.value = prs_acc;
            end
            num.end_index   = (prs_digits != DG_NONE) ? prs_idx : '0;
            num.digits_seen = (prs_digits != DG_NONE);
            num.overflowed  = (prs_digits == DG_OVER);
            num.minus_sign  = prs_neg;
            prs_phase = PH_DONE;
        end
    endtask

    // first character after white space and sign picks the base
    task automatic take_first(input logic [CHAR_W-1:0] c, output bit got,
                              output t_number num);
        got = 1'b0;
        num = '0;
        if ((cfg_radix == RADIX_AUTO || cfg_radix == RADIX_HEX) && c == CH_ZERO) begin
            prs_base  = (cfg_radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
            prs_phase = PH_ZERO;
        end else begin
            prs_base  = (cfg_radix == RADIX_AUTO) ? RADIX_DEC : cfg_radix;
            prs_phase = PH_DIGITS;
            digit_or_end(c, got, num);
        end
    endtask

    task automatic parse_char(input t_char_item it, output bit got, output t_number num);
        got = 1'b0;
        num = '0;
        if (it.first) begin
            prs_phase  = PH_LEAD;
            prs_base   = '0;
            prs_acc    = '0;
            prs_digits = DG_NONE;
            prs_neg    = 1'b0;
            prs_idx    = '0;
        end else begin
            if (prs_phase == PH_DONE) return;
            if (prs_idx != '1) prs_idx++;
        end
        case (prs_phase)
            PH_LEAD: begin
                if (!(it.code == CH_SPACE || (it.code >= CH_TAB && it.code <= CH_CR))) begin
                    if (it.code == CH_MINUS) begin
                        prs_neg   = 1'b1;
                        prs_phase = PH_SIGNED;
                    end else if (it.code == CH_PLUS) begin
                        prs_phase = PH_SIGNED;
                    end else begin
                        take_first(it.code, got, num);
                    end
                end
            end
            PH_SIGNED: begin
                take_first(it.code, got, num);
            end
            PH_ZERO: begin
                if (it.code == CH_LO_X || it.code == CH_UP_X) begin
                    prs_base  = RADIX_HEX;
                    prs_phase = PH_DIGITS;
                end else begin
                    add_digit(7'd0);
                    prs_phase = PH_DIGITS;
                    digit_or_end(it.code, got, num);
                end
            end
            PH_DIGITS: begin
                digit_or_end(it.code, got, num);
            end
            default: begin
                prs_phase = PH_DONE;
            end
        endcase
    endtask

    // monitor: predict on every input transaction, check every result transaction
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_num = {o_value, o_end_index, o_digits_seen, o_overflowed, o_minus_sign};
            if (expected_numbers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result at %0t: value %h end %0d", $time,
                             o_value, o_end_index);
                end
            end else begin
                want_num = expected_numbers.pop_front();
                numbers_checked++;
                if (seen_num !== want_num) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: expected value %h end %0d dig %0b ovf %0b neg %0b",
                                 $time, want_num.value, want_num.end_index,
                                 want_num.digits_seen, want_num.overflowed,
                                 want_num.minus_sign);
                        $display("    actual value %h end %0d dig %0b ovf %0b neg %0b",
                                 seen_num.value, seen_num.end_index, seen_num.digits_seen,
                                 seen_num.overflowed, seen_num.minus_sign);
                    end
                end
            end
        end
        if (in_taken) begin
            parse_char({i_first_char, i_char_code}, pred_got, pred_num);
            if (pred_got) expected_numbers.push_back(pred_num);
            chars_taken++;
        end
    end

    // sender: holds each transaction until taken, random gap bursts between
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (tx_idle_left > 0) begin
                tx_idle_left--;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                tx_idle_left = $urandom_range(1, 19);
            end
            if (tx_idle_left == 0 && pending_chars.size() != 0) begin
                next_item = pending_chars.pop_front();
                i_first_char <= next_item.first;
                i_char_code  <= next_item.code;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts plus one long hold-off
    always @(negedge i_clk) begin
        if (rx_idle_left > 0) begin
            rx_idle_left--;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rx_idle_left = $urandom_range(1, 19);
        end
        i_out_ready <= !long_hold && rx_idle_left == 0;
    end

    initial begin
        wait (pressure_arm);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        #150_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic put_char(input logic [CHAR_W-1:0] c);
        pending_chars.push_back({mark_next, c});
        mark_next = 1'b0;
        chars_queued++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    task automatic start_string();
        mark_next = 1'b1;
        strings_sent++;
    endtask

    task automatic send_number(input string s, input logic [CHAR_W-1:0] term);
        start_string();
        put_text(s);
        put_char(term);
    endtask

    task automatic put_digit(input logic [RADIX_W-1:0] b);
        int lim;
        int v;
        lim = (b > 36) ? 36 : b;
        v = $urandom_range(0, lim - 1);
        if (v < 10) begin
            put_char(CH_ZERO + 8'(v));
        end else if ($urandom_range(0, 1) == 0) begin
            put_char(UP_BIAS + 8'(v));
        end else begin
            put_char(LO_BIAS + 8'(v));
        end
    endtask

    // mostly well-formed numbers with random content, some broken ones and noise
    task automatic random_string();
        int n_ws;
        int n_dig;
        int sel;
        logic [RADIX_W-1:0] gb;
        start_string();
        n_ws = $urandom_range(0, 3);
        for (int i = 0; i < n_ws; i++) begin
            if ($urandom_range(0, 1) == 0) put_char(CH_SPACE);
            else put_char(CH_TAB + 8'($urandom_range(0, 4)));
        end
        sel = $urandom_range(0, 3);
        if (sel == 0) put_char(CH_MINUS);
        else if (sel == 1) put_char(CH_PLUS);
        gb = (cfg_radix == RADIX_AUTO) ? RADIX_DEC : cfg_radix;
        sel = $urandom_range(0, 3);
        if (sel == 0 && (cfg_radix == RADIX_AUTO || cfg_radix == RADIX_HEX)) begin
            put_char(CH_ZERO);
            put_char(($urandom_range(0, 1) == 0) ? CH_LO_X : CH_UP_X);
            gb = RADIX_HEX;
        end else if (sel == 1) begin
            put_char(CH_ZERO);
            if (cfg_radix == RADIX_AUTO) gb = RADIX_OCT;
        end
        n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        for (int i = 0; i < n_dig; i++) begin
            if ($urandom_range(0, 29) == 0) put_char(8'($urandom_range(0, 255)));
            else put_digit(gb);
        end
        sel = $urandom_range(0, 3);
        if (sel == 0) put_char(CH_NUL);
        else if (sel == 1) put_char(8'($urandom_range(0, 255)));
        else if (sel == 2) put_char(8'($urandom_range(128, 255)));
        else put_char(CH_SPACE);
        // junk after the end is ignored
        repeat ($urandom_range(0, 2)) put_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                mark_next = ($urandom_range(0, 1) == 1);
                put_char(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_chars.size() != 0 || i_in_valid || expected_numbers.size() != 0)
            @(posedge i_clk);
        // characters that end no number may still be in the pipeline
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [RADIX_W-1:0] r);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        cfg_radix = r;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    logic [RADIX_W-1:0] radix_sweep[10] = '{6'd0, 6'd16, 6'd10, 6'd8, 6'd2, 6'd36,
                                            6'd1, 6'd37, 6'd63, 6'd10};

    initial begin
        int phase_mark;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset radix: decimal
        put_text("12");
        send_number("  -123", CH_NUL);
        send_number("+4294967295", CH_NUL);
        send_number("4294967296", CH_SPACE);
        send_number("-99999999999", 8'hff);
        send_number("abc", CH_NUL);
        send_number("-", CH_NUL);
        start_string();
        for (int i = 0; i < 5; i++) put_char(CH_TAB + 8'(i));
        put_char(CH_SPACE);
        put_text("9");
        put_char(8'h80);
        put_text("55");
        send_number("0", CH_NUL);

        cfg_write(RADIX_AUTO);
        send_number("0x1F", CH_NUL);
        send_number("0X", "g");
        send_number("017", CH_NUL);
        send_number("089", CH_NUL);
        send_number("-123", CH_NUL);
        send_number("0", CH_NUL);

        cfg_write(RADIX_HEX);
        send_number("0xffffffff", CH_NUL);
        send_number("DeadBeef", 8'h7f);
        send_number("-0x10", CH_NUL);
        send_number("0x100000000", CH_NUL);

        cfg_write(6'd36);
        send_number("zZ", CH_NUL);
        cfg_write(6'd1);
        send_number("0001", CH_NUL);
        cfg_write(6'd63);
        send_number("z9Zz", "!");

        // long run of zeros ahead of the last digit
        cfg_write(RADIX_DEC);
        start_string();
        repeat (40) put_char(CH_ZERO);
        put_text("7");
        put_char(CH_NUL);

        for (int k = 0; k < 10; k++) begin
            if (k == 9) begin
                wait_idle();
                quiet = 1'b1;
                radix_sweep[k] = 6'($urandom_range(0, 63));
            end
            cfg_write(radix_sweep[k]);
            phase_mark = chars_queued;
            while (chars_queued - phase_mark < 180) random_string();
            if (k == 0) pressure_arm = 1'b1;
        end

        wait_idle();
        $display("covered %0d strings under %0d radix settings, %0d characters taken",
                 strings_sent, settings_used, chars_taken);
        $display("%0d numbers compared, %0d mismatches", numbers_checked, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
